[hw/rtl/lnr_pkg.sv]
// Package for the row layer normalization block: types, constants and field widths.
`default_nettype none
package lnr_pkg;
	localparam int RowMax = 64;
	localparam int IdxW = $clog2(RowMax);
	localparam int CntW = $clog2(RowMax + 1);
	localparam int DataW = 16;
	localparam int SumW = 24;
	localparam int Sq2W = 40;
	localparam int NumW = 56;
	localparam int RootW = 40;
	localparam int DenW = RootW + CntW;
	localparam int ProdW = 64;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SQ,
		ST_SQACC,
		ST_NUM,
		ST_VSTART,
		ST_DIVV,
		ST_ROOT,
		ST_DEN,
		ST_RD,
		ST_D,
		ST_P,
		ST_QSTART,
		ST_DIVQ,
		ST_OUT
	} lnr_state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} lnr_div_ctl_t;
endpackage
`default_nettype wire

[hw/rtl/layer_norm_row.sv]
// Top level of the row layer normalization block.
// Loading accepts one element transfer per cycle; the block is ready while loading.
// After the last-marked transfer of a row: a sum-of-squares pass over the row, the setup
// states ST_NUM and ST_VSTART, the variance division, the square root and the divisor.
// Each result then takes four setup steps, a pass through the shared divider and the output
// state, where it waits while a held result is not yet taken by m_tready.
// Async reset clears control state and sets epsilon to 1; the row buffer is not cleared.
`default_nettype none
module layer_norm_row (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // sample, gain, offset from bit 0 up
	input  wire logic        s_tlast,   // last_in_row
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // normalized
	output logic             m_tlast,   // last_out
	output logic             m_tuser    // clipped or row truncated
);
	import lnr_pkg::*;

	// Row buffer and registered read data; entries are written only at the fill count.
	logic [3*DataW-1:0] row_mem [RowMax];
	logic [3*DataW-1:0] rd_s2;

	lnr_state_t state_q, state_d;
	logic [CntW-1:0] fill_q;
	logic [IdxW-1:0] idx_q;
	logic signed [SumW-1:0] sum_q;
	logic [Sq2W-1:0] sq_q;
	logic [31:0] sqp_q;
	logic cut_q;
	logic [15:0] eps_q;
	logic [NumW-1:0] num_q;
	logic [ProdW-1:0] v_q;
	logic [ProdW-1:0] rad_q;
	logic [RootW-1:0] res_q;
	logic [5:0] rcnt_q;
	logic [DenW-1:0] den_q;
	logic signed [31:0] d_q;
	logic signed [ProdW-1:0] p_q;
	logic [15:0] out_q;
	logic last_q, user_q, mval_q;
	logic m_tlast_q;

	logic accept;
	logic div_start;
	logic [ProdW-1:0] div_a, div_b, div_quo;
	lnr_div_ctl_t div_ctl;

	// Sign-extended sample and gain of the element being read.
	logic signed [31:0] xs_ext;
	logic signed [ProdW-1:0] gs_ext;
	assign xs_ext = 32'($signed(rd_s2[15:0]));
	assign gs_ext = ProdW'($signed(rd_s2[31:16]));

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_LOAD);

	always_ff @(posedge clk) begin
		if (accept && fill_q < CntW'(RowMax)) begin
			row_mem[fill_q[IdxW-1:0]] <= s_tdata;
		end
		rd_s2 <= row_mem[idx_q];
	end

	lnr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_a), .divisor(div_b), .ctl(div_ctl), .quotient(div_quo)
	);

	// Root: bitwise integer square root of v*2^32, two bits of radicand per step.
	logic [RootW+1:0] rtrial;
	logic [RootW+1:0] rrem_n;
	logic [RootW+1:0] rrem_q;
	assign rrem_n = {rrem_q[RootW-1:0], rad_q[ProdW-1 -: 2]};
	assign rtrial = rrem_n - {res_q, 2'b01};

	logic signed [ProdW-1:0] pmag_sel;
	logic pneg;
	assign pneg = p_q[ProdW-1];
	assign pmag_sel = pneg ? -p_q : p_q;

	logic signed [ProdW:0] y;
	logic signed [DataW-1:0] off_v;
	assign off_v = rd_s2[3*DataW-1:2*DataW];

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_a = '0;
		div_b = '0;
		unique case (state_q)
			ST_LOAD: if (accept && s_tlast) state_d = ST_SQ;
			ST_SQ: state_d = ST_SQACC;
			ST_SQACC: state_d = (CntW'(idx_q) + 1'b1 == fill_q) ? ST_NUM : ST_SQ;
			ST_NUM: state_d = ST_VSTART;
			ST_VSTART: begin
				state_d = ST_DIVV;
				div_start = 1'b1;
			end
			ST_DIVV: begin
				div_a = ProdW'(num_q);
				div_b = ProdW'(fill_q) * ProdW'(fill_q);
				if (div_ctl.start) begin
					div_a = ProdW'(num_q);
				end
				if (!div_ctl.busy && !div_ctl.start) state_d = ST_ROOT;
			end
			ST_ROOT: if (rcnt_q == 6'd32) state_d = ST_DEN;
			ST_DEN: state_d = ST_RD;
			ST_RD: state_d = ST_D;
			ST_D: state_d = ST_P;
			ST_P: state_d = ST_QSTART;
			ST_QSTART: begin
				state_d = ST_DIVQ;
				div_start = 1'b1;
			end
			ST_DIVQ: if (!div_ctl.busy && !div_ctl.start) state_d = ST_OUT;
			ST_OUT: if (!mval_q || m_tready) state_d = last_q ? ST_LOAD : ST_RD;
			default: state_d = ST_LOAD;
		endcase
		// The divider registers its operands in the cycle that start is raised.
		if (state_q == ST_VSTART) begin
			div_a = ProdW'(num_q);
			div_b = ProdW'(fill_q) * ProdW'(fill_q);
		end
		if (state_q == ST_QSTART) begin
			div_a = pmag_sel + ProdW'(den_q >> 1);
			div_b = ProdW'(den_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q <= '0;
			sum_q <= '0;
			cut_q <= 1'b0;
			eps_q <= 16'd1;
			mval_q <= 1'b0;
			idx_q <= '0;
			rcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) eps_q <= cfg_wdata;
			if (mval_q && m_tready) mval_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					idx_q <= '0;
					if (accept) begin
						if (fill_q < CntW'(RowMax)) begin
							fill_q <= fill_q + 1'b1;
							sum_q <= sum_q + SumW'($signed(s_tdata[15:0]));
						end else begin
							cut_q <= 1'b1;
						end
					end
				end
				ST_SQACC: if (CntW'(idx_q) + 1'b1 != fill_q) idx_q <= idx_q + 1'b1;
				ST_NUM: rcnt_q <= '0;
				ST_ROOT: rcnt_q <= rcnt_q + 1'b1;
				ST_DEN: idx_q <= '0;
				ST_OUT: begin
					if (!mval_q || m_tready) begin
						mval_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
						if (last_q) begin
							fill_q <= '0;
							sum_q <= '0;
							cut_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: sq_q <= '0;
			ST_SQ: ;
			ST_SQACC: begin
				sqp_q <= $unsigned(xs_ext * xs_ext);
			end
			ST_NUM: begin
				num_q <= NumW'(fill_q) * NumW'(sq_q + Sq2W'(sqp_q))
					- NumW'(sum_q) * NumW'(sum_q);
				sq_q <= sq_q + Sq2W'(sqp_q);
			end
			ST_DIVV: begin
				v_q <= div_quo + ProdW'(eps_q);
				rad_q <= (div_quo + ProdW'(eps_q)) << 32;
				res_q <= '0;
				rrem_q <= '0;
			end
			ST_ROOT: if (rcnt_q != 6'd32) begin
				rad_q <= rad_q << 2;
				if (!rtrial[RootW+1]) begin
					rrem_q <= rtrial;
					res_q <= {res_q[RootW-2:0], 1'b1};
				end else begin
					rrem_q <= rrem_n;
					res_q <= {res_q[RootW-2:0], 1'b0};
				end
			end
			ST_DEN: den_q <= DenW'(fill_q) * DenW'(res_q);
			ST_RD: ;
			ST_D: d_q <= $signed({{(32-CntW){1'b0}}, fill_q}) * xs_ext - 32'(sum_q);
			ST_P: ;
			ST_DIVQ: ;
			ST_OUT: if (!mval_q || m_tready) begin
				out_q <= (y > 32767) ? 16'h7fff : (y < -32768) ? 16'h8000 : y[15:0];
				user_q <= (y > 32767) || (y < -32768) || cut_q;
				m_tlast_q <= last_q;
			end
			default: ;
		endcase
		if (state_q == ST_SQ && idx_q != '0) sq_q <= sq_q + Sq2W'(sqp_q);
		if (state_q == ST_P) p_q <= (ProdW'(d_q) * gs_ext) <<< 16;
		last_q <= (CntW'(idx_q) + 1'b1 == fill_q);
	end

	logic signed [ProdW:0] qv;
	assign qv = (v_q == '0) ? '0 : (pneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo}));
	assign y = qv + (ProdW+1)'(off_v);

	assign m_tvalid = mval_q;
	assign m_tdata = out_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = user_q;

`ifndef ASSERT_OFF
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !s_tready) else $error("ready while busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntW'(RowMax)) else $error("fill count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif
endmodule
`default_nettype wire

[hw/rtl/lnr_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module lnr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lnr_pkg::ProdW-1:0]  dividend,
	input  wire logic [lnr_pkg::ProdW-1:0]  divisor,
	output lnr_pkg::lnr_div_ctl_t           ctl,
	output logic      [lnr_pkg::ProdW-1:0]  quotient
);
	import lnr_pkg::*;

	logic [ProdW-1:0] rem_q;
	logic [ProdW-1:0] quo_q;
	logic [ProdW-1:0] dsr_q;
	logic [$clog2(ProdW+1)-1:0] cnt_q;
	logic [ProdW:0] trial;

	assign trial = {rem_q, quo_q[ProdW-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ($clog2(ProdW+1))'(ProdW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[ProdW]) begin
				rem_q <= trial[ProdW-1:0];
				quo_q <= {quo_q[ProdW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[ProdW-2:0], quo_q[ProdW-1]};
				quo_q <= {quo_q[ProdW-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = (cnt_q != '0);
	assign quotient = quo_q;
endmodule
`default_nettype wire
